// ----- rtl/tkst_pkg.sv -----
// Shared types for the top-k sorted insert table.
package tkst_pkg;

   // Operation codes carried on the request tuser bit
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   // Field widths fixed by the word formats
   localparam int TAG_W   = 16;
   localparam int SCORE_W = 32;
   localparam int INDEX_W = 6;
   localparam int RANK_W  = 5;

   // Request tdata: entry_tag, entry_score, read_index, zero pad to 56 bits
   localparam int REQ_DATA_W = 56;
   // Response tdata: out_tag, out_score, rank, entry_count, zero pad to 64 bits
   localparam int RSP_DATA_W = 64;

   // One table entry as held by a cell
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } entry_type;

   // Insert command broadcast to every cell
   typedef struct packed {
      logic      ins_en;
      entry_type entry;
   } ins_cmd_type;

endpackage

// ----- rtl/tkst_cell.sv -----
// One rank position of the sorted table: compare against the new score and shift.
module tkst_cell (
   input  logic                 clock,
   input  tkst_pkg::ins_cmd_type cmd,
   input  logic                 occupied,
   input  tkst_pkg::entry_type  left_entry,
   input  logic                 left_ge,
   output tkst_pkg::entry_type  entry,
   output logic                 ge
);

   tkst_pkg::entry_type entry_ff;
   tkst_pkg::entry_type entry_in;

   // Held entry stays ahead of the new one when its score is equal or greater
   assign ge = occupied && (entry_ff.score >= cmd.entry.score);

   // Keep, take the new entry at the boundary, or take the left neighbor
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en && !ge) begin
         if (left_ge) begin
            entry_in = cmd.entry;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/tkst_pick.sv -----
// Insert position encoder and read selector over the row of cells.
module tkst_pick #(
   parameter int MAX_ENTRIES = 16,
   parameter int CW          = 5,
   parameter int IW          = 4
) (
   input  logic [MAX_ENTRIES-1:0] ge,
   input  tkst_pkg::entry_type    entries [MAX_ENTRIES],
   input  logic [IW-1:0]          read_addr,
   output logic [CW-1:0]          pos,
   output tkst_pkg::entry_type    rd_entry
);

   logic [MAX_ENTRIES:0]   ge_ext;
   logic [MAX_ENTRIES-1:0] ge_up;

   // Neighbor-to-the-right view of the compare flags
   assign ge_ext = {1'b0, ge};
   assign ge_up  = ge_ext[MAX_ENTRIES:1];

   // Flags form a prefix: the last set flag marks the insert position
   always_comb begin
      pos = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (ge[i] && !ge_up[i]) begin
            pos = pos | CW'(i + 1);
         end
      end
   end

   // Select the entry at the requested rank
   assign rd_entry = entries[read_addr];

endmodule

// ----- rtl/top_k_sorted_insert_table.sv -----
// Top level of the top-k sorted insert table: cell row, count and response register.
//
// Keeps up to MAX_ENTRIES entries (signed 32-bit score, 16-bit tag) in
// descending score order; equal scores keep arrival order.
// Request channel (req_): tuser selects insert or read, tdata carries the
// tag, score and read index. Every request word gives one response word.
// Response channel (rsp_): tuser is the valid flag, tdata carries the tag
// and score read, the rank and the entry count after the word.
// An insert lands after every held entry with an equal or greater score;
// with the table full the last entry falls off, or the new one is dropped
// (rank MAX_ENTRIES) if it is not above the last. A read at or past the
// count returns valid 0, zero payload and rank equal to the count.
// The response is registered and shows in the cycle after the request word.
// Throughput: one word per cycle while the receiver takes each response;
// every cell compares and shifts in the same cycle, so the row itself sets the rate.
// Reset clears the entry count and the response valid; the table is empty
// and no request word is taken while reset is high.
// When the receiver stalls, the response holds and a new request is taken
// only in the cycle the held response leaves.
module top_k_sorted_insert_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] entry_tag, [47:16] entry_score, [53:48] read_index, rest zero
   input  logic [tkst_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] out_tag, [47:16] out_score, [52:48] rank, [57:53] entry_count
   output logic [tkst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] valid_res
   output logic                            rsp_tuser
);

   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMPW = (CW > tkst_pkg::INDEX_W) ? CW : tkst_pkg::INDEX_W;
   localparam int TW   = tkst_pkg::TAG_W;
   localparam int SW   = tkst_pkg::SCORE_W;
   localparam int XW   = tkst_pkg::INDEX_W;
   localparam int RW   = tkst_pkg::RANK_W;
   localparam int PADW = tkst_pkg::RSP_DATA_W - TW - SW - 2 * RW;

   // Request fields
   logic                  req_take;
   tkst_pkg::op_type      req_op;
   logic [TW-1:0]         req_tag;
   logic signed [SW-1:0]  req_score;
   logic [XW-1:0]         req_index;

   // Table state
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   tkst_pkg::ins_cmd_type  cmd;
   logic [MAX_ENTRIES-1:0] occupied;
   logic [MAX_ENTRIES-1:0] ge;
   tkst_pkg::entry_type    entries [MAX_ENTRIES];
   logic [CW-1:0]          pos;
   tkst_pkg::entry_type    rd_entry;

   // Result and response register
   logic [CMPW-1:0]       idx_ext;
   logic [CMPW-1:0]       cnt_ext;
   logic                  res_valid;
   logic [TW-1:0]         res_tag;
   logic [SW-1:0]         res_score;
   logic [CW-1:0]         res_rank;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [tkst_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [tkst_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_user_ff;
   logic                  rsp_user_in;

   // Unpack the request word
   assign req_take  = req_tvalid && req_tready;
   assign req_op    = tkst_pkg::op_type'(req_tuser);
   assign req_tag   = req_tdata[TW-1:0];
   assign req_score = req_tdata[TW+SW-1:TW];
   assign req_index = req_tdata[TW+SW+XW-1:TW+SW];

   // Broadcast the insert to the row
   assign cmd.ins_en      = req_take && (req_op == tkst_pkg::OP_INSERT);
   assign cmd.entry.score = req_score;
   assign cmd.entry.tag   = req_tag;

   // Mark ranks below the count as holding an entry
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         occupied[i] = CW'(i) < count_ff;
      end
   end

   // Row of compare-and-shift cells
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         tkst_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[g]),
            .left_entry (cmd.entry),
            .left_ge    (1'b1),
            .entry      (entries[g]),
            .ge         (ge[g])
         );
      end else begin : g_body
         tkst_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[g]),
            .left_entry (entries[g-1]),
            .left_ge    (ge[g-1]),
            .entry      (entries[g]),
            .ge         (ge[g])
         );
      end
   end

   tkst_pick #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CW          (CW),
      .IW          (IW)
   ) u_pick (
      .ge        (ge),
      .entries   (entries),
      .read_addr (req_index[IW-1:0]),
      .pos       (pos),
      .rd_entry  (rd_entry)
   );

   // Advance the count on a kept insert below capacity
   always_comb begin
      count_in = count_ff;
      if (cmd.ins_en && (count_ff < CW'(MAX_ENTRIES))) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Form the result for the word taken this cycle
   assign idx_ext = CMPW'(req_index);
   assign cnt_ext = CMPW'(count_ff);

   always_comb begin
      res_valid = 1'b0;
      res_tag   = '0;
      res_score = '0;
      res_rank  = pos;
      case (req_op)
         tkst_pkg::OP_INSERT: begin
            res_valid = !ge[MAX_ENTRIES-1];
            res_rank  = pos;
         end
         tkst_pkg::OP_READ: begin
            if (idx_ext < cnt_ext) begin
               res_valid = 1'b1;
               res_tag   = rd_entry.tag;
               res_score = rd_entry.score;
               res_rank  = CW'(req_index);
            end else begin
               res_rank  = count_ff;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Hold the response until taken; accept a new word as it leaves
   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = req_take ?
                         {PADW'(0), RW'(count_in), RW'(res_rank), res_score, res_tag} :
                         rsp_data_ff;
   assign rsp_user_in  = req_take ? res_valid : rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
